FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the divider project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define SID_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define SID_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: src/sid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_pkg
// types and constants shared by the signed divider cells and top level
// ----------------------------------------------------------------------------
package sid_pkg;

  localparam int WORD_W = 32;          // operand and quotient width
  localparam int MAG_W  = WORD_W + 1;  // magnitude width, holds 2^31
  localparam int STEPS  = MAG_W;       // one quotient bit per cell

  localparam logic [WORD_W-1:0] QUO_MAX = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] QUO_MIN = 32'h8000_0000;
  localparam logic [MAG_W-1:0]  POS_SAT = {1'b0, QUO_MAX};
  localparam logic [MAG_W-1:0]  NEG_SAT = {1'b0, QUO_MIN};  // QUO_MAX + 1

  // payload handed from cell to cell
  typedef struct packed {
    logic              neg;   // quotient takes a minus sign
    logic              dz;    // divisor was zero
    logic [MAG_W-1:0]  rem;   // partial remainder
    logic [MAG_W-1:0]  num;   // dividend magnitude, next bit on top
    logic [WORD_W-1:0] den;   // divisor magnitude
    logic [MAG_W-1:0]  quo;   // quotient bits so far
  } sid_stage_t;

endpackage

FILE: src/sid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_cell
// one restoring shift-subtract step, registered toward the next cell
// ----------------------------------------------------------------------------
module sid_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  sid_pkg::sid_stage_t stage_i,
  output logic               valid_o,
  output sid_pkg::sid_stage_t stage_o
);
  import sid_pkg::*;

  logic [MAG_W-1:0] rem_sh;
  logic             take;
  sid_stage_t       stage_nxt;
  sid_stage_t       stage_r;
  logic             valid_r;

  always_comb begin
    rem_sh              = {stage_i.rem[MAG_W-2:0], stage_i.num[MAG_W-1]};
    take                = rem_sh >= {1'b0, stage_i.den};
    stage_nxt           = stage_i;
    stage_nxt.rem       = take ? (rem_sh - {1'b0, stage_i.den}) : rem_sh;
    stage_nxt.num       = {stage_i.num[MAG_W-2:0], 1'b0};
    stage_nxt.quo       = {stage_i.quo[MAG_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign valid_o = valid_r;
  assign stage_o = stage_r;

endmodule

FILE: src/sid_fixup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sid_fixup
// applies sign, saturation and the zero-divisor override to a magnitude
// ----------------------------------------------------------------------------
module sid_fixup (
  input  sid_pkg::sid_stage_t          stage_i,
  output logic [sid_pkg::WORD_W-1:0]   quotient,
  output logic                         divide_by_zero
);
  import sid_pkg::*;

  always_comb begin
    divide_by_zero = stage_i.dz;
    if (stage_i.dz) begin
      quotient = '0;
    end else if (!stage_i.neg) begin
      quotient = (stage_i.quo >= POS_SAT) ? QUO_MAX : stage_i.quo[WORD_W-1:0];
    end else begin
      quotient = (stage_i.quo >= NEG_SAT) ? QUO_MIN
                                          : (WORD_W'(0) - stage_i.quo[WORD_W-1:0]);
    end
  end

endmodule

FILE: src/signed_integer_divider_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_divider_core
// signed 32-bit divider, truncating toward zero, saturating, zero-divisor flag
// ----------------------------------------------------------------------------
//  channel | ports                        | carries
//  --------+------------------------------+----------------------------------
//  in      | in_tvalid/in_tready/in_tdata | dividend [31:0], divisor [63:32]
//  out     | out_tvalid/out_tready/       | quotient [31:0] in tdata,
//          | out_tdata/out_tuser          | divide_by_zero in tuser
//
//  from request to result a request passes one operand register, 33
//  divide cells (one quotient bit each), one output register
//  a new request can enter every cycle while the output is not stalled; up to 35 requests are in flight
//  a held result with out_tready low freezes the whole chain and drops in_tready
//  synchronous active-low reset clears all valid bits; payload is not reset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module signed_integer_divider_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] dividend, [63:32] divisor
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] quotient
  output logic        out_tuser    // [0] divide_by_zero
);
  import sid_pkg::*;

  // chain advances whenever the output register is free or being drained
  logic en;

  // operand stage feeding cell 0
  logic [WORD_W-1:0] dividend;
  logic [WORD_W-1:0] divisor;
  logic [MAG_W-1:0]  dividend_mag;
  logic [MAG_W-1:0]  divisor_mag;
  sid_stage_t        stage0_nxt;
  sid_stage_t        stage0_r;
  logic              valid0_r;

  // chain links: index k feeds cell k, index STEPS is the last cell output
  sid_stage_t        stage_w [0:STEPS];
  logic              valid_w [0:STEPS];

  // output register
  logic [WORD_W-1:0] quotient;
  logic              divide_by_zero;
  logic [WORD_W-1:0] quotient_r;
  logic              dz_r;
  logic              out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign dividend = in_tdata[WORD_W-1:0];
  assign divisor  = in_tdata[2*WORD_W-1:WORD_W];

  // two's complement magnitudes, 33 bits so the minimum value fits
  always_comb begin
    dividend_mag = dividend[WORD_W-1] ? ({1'b0, ~dividend} + MAG_W'(1)) : {1'b0, dividend};
    divisor_mag  = divisor[WORD_W-1]  ? ({1'b0, ~divisor}  + MAG_W'(1)) : {1'b0, divisor};

    stage0_nxt.neg = (dividend[WORD_W-1] != divisor[WORD_W-1]) && (dividend != '0);
    stage0_nxt.dz  = (divisor == '0);
    stage0_nxt.rem = '0;
    stage0_nxt.num = dividend_mag;
    stage0_nxt.den = divisor_mag[WORD_W-1:0];  // at most 2^31, fits 32 bits
    stage0_nxt.quo = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid0_r <= 1'b0;
    end else if (en) begin
      valid0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage0_r <= stage0_nxt;
    end
  end

  assign stage_w[0] = stage0_r;
  assign valid_w[0] = valid0_r;

  // row of divide cells, most significant quotient bit first
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    sid_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .valid_i (valid_w[k]),
      .stage_i (stage_w[k]),
      .valid_o (valid_w[k+1]),
      .stage_o (stage_w[k+1])
    );
  end

  // sign and saturation on the finished magnitude
  sid_fixup u_fixup (
    .stage_i        (stage_w[STEPS]),
    .quotient       (quotient),
    .divide_by_zero (divide_by_zero)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= valid_w[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient_r <= quotient;
      dz_r       <= divide_by_zero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = quotient_r;
  assign out_tuser  = dz_r;

  // zero divisor always reports a zero quotient
  `SID_ASSERT_NOW(a_dz_zero_quo, clk, rst_n, out_valid_r && dz_r, quotient_r == '0)

  // a result appears only after the last cell held a valid request
  `SID_ASSERT_NOW(a_out_from_chain, clk, rst_n, $rose(out_valid_r), $past(valid_w[STEPS]))

  // a stalled chain keeps the last cell contents
  `SID_ASSERT_NEXT(a_chain_freeze, clk, rst_n, !en && valid_w[STEPS], $stable(stage_w[STEPS]) && valid_w[STEPS])

  // zero-divisor flag in the operand stage matches the stored divisor
  `SID_ASSERT_NOW(a_dz_flag, clk, rst_n, valid0_r, stage0_r.dz == (stage0_r.den == '0))

endmodule
